@@ hw/rtl/skrt_pkg.sv @@
// ----------------------------------------------------------------------------
// skrt_pkg
// shared constants, codes and control types of the session key replay table
// ----------------------------------------------------------------------------
`default_nettype none

package skrt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 256;
    localparam int NONCE_BITS  = 64;

    localparam int WORD_W  = 64;
    localparam int KEY_W   = 4 * WORD_W;
    localparam int COUNT_W = 5;
    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ACT_REGISTER = 3'd0,
        ACT_REMOVE   = 3'd1,
        ACT_FIND     = 3'd2,
        ACT_COMMIT   = 3'd3,
        ACT_CLEAR    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_STALE     = 2'd2,
        STS_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic capture;
        logic lookup;
        logic read;
        logic exec;
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ hw/rtl/skrt_ram.sv @@
// ----------------------------------------------------------------------------
// skrt_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module skrt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/skrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// skrt_ctrl
// request sequencer: capture, id lookup, memory read, execute
// ----------------------------------------------------------------------------
`default_nettype none

module skrt_ctrl (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    output logic          o_busy,
    output skrt_pkg::t_dp_cmd o_cmd
);

    import skrt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOKUP = 4'b0010,
        ST_READ   = 4'b0100,
        ST_EXEC   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

@@ hw/rtl/skrt_datapath.sv @@
// ----------------------------------------------------------------------------
// skrt_datapath
// id compare bank, valid bits, entry count, material memories and result regs
// ----------------------------------------------------------------------------
`default_nettype none

module skrt_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire skrt_pkg::t_dp_cmd i_cmd,
    input  wire logic [2:0]        i_action,
    input  wire logic [63:0]       i_session_id_hi,
    input  wire logic [63:0]       i_session_id_lo,
    input  wire logic [63:0]       i_key_word0,
    input  wire logic [63:0]       i_key_word1,
    input  wire logic [63:0]       i_key_word2,
    input  wire logic [63:0]       i_key_word3,
    input  wire logic [63:0]       i_nonce_prefix,
    input  wire logic [63:0]       i_sequence_req,
    output logic                   o_result_valid,
    output logic [1:0]             o_status,
    output logic [63:0]            o_key_out0,
    output logic [63:0]            o_key_out1,
    output logic [63:0]            o_key_out2,
    output logic [63:0]            o_key_out3,
    output logic [63:0]            o_nonce_out,
    output logic [63:0]            o_last_seq_out,
    output logic [4:0]             o_entry_count
);

    import skrt_pkg::*;

    // captured request
    t_action               r_action;
    logic [WORD_W-1:0]     r_id_hi;
    logic [WORD_W-1:0]     r_id_lo;
    logic [KEY_BITS-1:0]   r_key;
    logic [NONCE_BITS-1:0] r_nonce;
    logic [WORD_W-1:0]     r_seq;

    // table state
    logic [TABLE_DEPTH-1:0] r_vld;
    logic [WORD_W-1:0]      r_tab_hi [TABLE_DEPTH];
    logic [WORD_W-1:0]      r_tab_lo [TABLE_DEPTH];
    logic [CNT_W-1:0]       r_count;

    // lookup results
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic             r_free_any;
    logic [IDX_W-1:0] r_free_idx;
    logic             n_hit;
    logic [IDX_W-1:0] n_hit_idx;
    logic             n_free_any;
    logic [IDX_W-1:0] n_free_idx;

    // memory read data
    logic [KEY_BITS-1:0]   key_rd;
    logic [NONCE_BITS-1:0] nonce_rd;
    logic [WORD_W-1:0]     seq_rd;

    // execute decisions
    t_status               n_status;
    logic [CNT_W-1:0]      n_count;
    logic [IDX_W-1:0]      slot;
    logic                  ent_wr;
    logic                  ent_clr;
    logic                  clr_all;
    logic                  show;
    logic                  mat_we;
    logic                  seq_we;
    logic [KEY_BITS-1:0]   key_wd;
    logic [NONCE_BITS-1:0] nonce_wd;
    logic [WORD_W-1:0]     seq_wd;

    logic [KEY_W-1:0]      key_in;
    logic [KEY_W-1:0]      key_show;

    assign key_in = {i_key_word0, i_key_word1, i_key_word2, i_key_word3};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= t_action'(i_action);
            r_id_hi  <= i_session_id_hi;
            r_id_lo  <= i_session_id_lo;
            r_key    <= key_in[KEY_BITS-1:0];
            r_nonce  <= i_nonce_prefix[NONCE_BITS-1:0];
            r_seq    <= i_sequence_req;
        end
    end

    // parallel id compare and lowest free slot
    always_comb begin
        n_hit      = 1'b0;
        n_hit_idx  = '0;
        n_free_any = 1'b0;
        n_free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (r_vld[i] && r_tab_hi[i] == r_id_hi && r_tab_lo[i] == r_id_lo) begin
                n_hit     = 1'b1;
                n_hit_idx = IDX_W'(i);
            end
            if (!r_vld[i]) begin
                n_free_any = 1'b1;
                n_free_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_free_any <= n_free_any;
            r_free_idx <= n_free_idx;
        end
    end

    // execute
    always_comb begin
        n_status = STS_OK;
        n_count  = r_count;
        slot     = r_hit_idx;
        ent_wr   = 1'b0;
        ent_clr  = 1'b0;
        clr_all  = 1'b0;
        show     = 1'b0;
        mat_we   = 1'b0;
        seq_we   = 1'b0;
        key_wd   = r_key;
        nonce_wd = r_nonce;
        seq_wd   = '0;
        case (r_action)
            ACT_REGISTER: begin
                if (!r_hit && !r_free_any) begin
                    n_status = STS_FULL;
                end else begin
                    slot   = r_hit ? r_hit_idx : r_free_idx;
                    ent_wr = 1'b1;
                    mat_we = 1'b1;
                    seq_we = 1'b1;
                    if (!r_hit) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            ACT_REMOVE: begin
                if (!r_hit) begin
                    n_status = STS_NOT_FOUND;
                end else begin
                    ent_clr  = 1'b1;
                    mat_we   = 1'b1;
                    seq_we   = 1'b1;
                    key_wd   = '0;
                    nonce_wd = '0;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            ACT_FIND: begin
                if (!r_hit) begin
                    n_status = STS_NOT_FOUND;
                end else begin
                    show = 1'b1;
                end
            end
            ACT_COMMIT: begin
                if (r_seq == '0) begin
                    n_status = STS_STALE;
                end else if (!r_hit) begin
                    n_status = STS_NOT_FOUND;
                end else if (r_seq <= seq_rd) begin
                    n_status = STS_STALE;
                end else begin
                    seq_we = 1'b1;
                    seq_wd = r_seq;
                end
            end
            ACT_CLEAR: begin
                clr_all = 1'b1;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            if (clr_all) begin
                r_vld <= '0;
            end else if (ent_clr) begin
                r_vld[slot] <= 1'b0;
            end else if (ent_wr) begin
                r_vld[slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (clr_all) begin
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    r_tab_hi[i] <= '0;
                    r_tab_lo[i] <= '0;
                end
            end else if (ent_clr) begin
                r_tab_hi[slot] <= '0;
                r_tab_lo[slot] <= '0;
            end else if (ent_wr) begin
                r_tab_hi[slot] <= r_id_hi;
                r_tab_lo[slot] <= r_id_lo;
            end
        end
    end

    skrt_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && mat_we),
        .i_waddr (slot),
        .i_wdata (key_wd),
        .i_re    (i_cmd.read),
        .i_raddr (r_hit_idx),
        .o_rdata (key_rd)
    );

    skrt_ram #(.WIDTH(NONCE_BITS), .DEPTH(TABLE_DEPTH)) u_nonce_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && mat_we),
        .i_waddr (slot),
        .i_wdata (nonce_wd),
        .i_re    (i_cmd.read),
        .i_raddr (r_hit_idx),
        .o_rdata (nonce_rd)
    );

    skrt_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && seq_we),
        .i_waddr (slot),
        .i_wdata (seq_wd),
        .i_re    (i_cmd.read),
        .i_raddr (r_hit_idx),
        .o_rdata (seq_rd)
    );

    assign key_show = KEY_W'(key_rd);

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_result_valid <= 1'b0;
        end else begin
            o_result_valid <= i_cmd.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            o_status       <= n_status;
            o_entry_count  <= COUNT_W'(n_count);
            o_key_out0     <= show ? key_show[4*WORD_W-1:3*WORD_W] : '0;
            o_key_out1     <= show ? key_show[3*WORD_W-1:2*WORD_W] : '0;
            o_key_out2     <= show ? key_show[2*WORD_W-1:WORD_W]   : '0;
            o_key_out3     <= show ? key_show[WORD_W-1:0]          : '0;
            o_nonce_out    <= show ? WORD_W'(nonce_rd) : '0;
            o_last_seq_out <= show ? seq_rd : '0;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/session_key_replay_table_core.sv @@
// ----------------------------------------------------------------------------
// session_key_replay_table_core
// exact-match session table with key material and a replay sequence check
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low, and its result is
// presented for exactly one cycle on o_result_valid after the execute step;
// busy drops in that same cycle, so the next request can be taken while a
// result is shown. The steps of the sequencer are capture, a parallel compare
// of the session id against all entries, a registered read of the key, nonce
// and sequence memories, and the execute step that decides, writes back and
// loads the result registers. The receiver cannot stall, so a result must be
// taken in the cycle it is shown. No clearing pass follows reset: an entry's
// memory data is only used while its valid bit is set, after it was written.
// ----------------------------------------------------------------------------
`default_nettype none

module session_key_replay_table_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_action,
    input  wire logic [63:0] i_session_id_hi,
    input  wire logic [63:0] i_session_id_lo,
    input  wire logic [63:0] i_key_word0,
    input  wire logic [63:0] i_key_word1,
    input  wire logic [63:0] i_key_word2,
    input  wire logic [63:0] i_key_word3,
    input  wire logic [63:0] i_nonce_prefix,
    input  wire logic [63:0] i_sequence_req,
    output logic             o_result_valid,
    output logic [1:0]       o_status,
    output logic [63:0]      o_key_out0,
    output logic [63:0]      o_key_out1,
    output logic [63:0]      o_key_out2,
    output logic [63:0]      o_key_out3,
    output logic [63:0]      o_nonce_out,
    output logic [63:0]      o_last_seq_out,
    output logic [4:0]       o_entry_count
);

    import skrt_pkg::*;

    t_dp_cmd cmd;

    skrt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    skrt_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_action        (i_action),
        .i_session_id_hi (i_session_id_hi),
        .i_session_id_lo (i_session_id_lo),
        .i_key_word0     (i_key_word0),
        .i_key_word1     (i_key_word1),
        .i_key_word2     (i_key_word2),
        .i_key_word3     (i_key_word3),
        .i_nonce_prefix  (i_nonce_prefix),
        .i_sequence_req  (i_sequence_req),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_key_out0      (o_key_out0),
        .o_key_out1      (o_key_out1),
        .o_key_out2      (o_key_out2),
        .o_key_out3      (o_key_out3),
        .o_nonce_out     (o_nonce_out),
        .o_last_seq_out  (o_last_seq_out),
        .o_entry_count   (o_entry_count)
    );

    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while a request is still in progress");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_result_valid)
        else $error("accepted request did not produce a result in four cycles");

    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == STS_FULL) |-> o_entry_count == COUNT_W'(TABLE_DEPTH))
        else $error("table full reported with free entries");

    a_no_data_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != STS_OK) |->
        (o_key_out0 == '0 && o_key_out3 == '0 && o_nonce_out == '0 && o_last_seq_out == '0))
        else $error("key material shown on a failed request");

endmodule

`default_nettype wire

@@ tb/tb_session_key_replay_table_core.sv @@
// ----------------------------------------------------------------------------
// tb_session_key_replay_table_core
// self-checking bench for the session key replay table core
// ----------------------------------------------------------------------------
// A short directed table covers the empty table, all-ones and all-zero ids and
// material, the zero, stale and wrapped sequence cases, overwrite, the unused
// action codes and clear. Random requests follow, most ids from a small pool so
// that the table fills and entries are reused. Every request is run through a
// local copy of the table when it is taken, and each strobed result is checked
// field by field against the oldest pending answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_session_key_replay_table_core;

    import skrt_pkg::*;

    localparam int          RANDOM_REQUESTS = 750;
    localparam int          ROW_LIMIT       = 32;
    localparam int          ANSWER_LIMIT    = RANDOM_REQUESTS + ROW_LIMIT;
    localparam int          LIMIT_CYCLES    = 400000;
    localparam int          POOL_SIZE       = 24;
    localparam logic [63:0] ALL1            = {64{1'b1}};
    localparam logic [2:0]  ACT_SPARE_LO    = 3'd5;
    localparam logic [2:0]  ACT_SPARE_HI    = 3'd7;

    typedef struct packed {
        logic [2:0]       action;
        logic [63:0]      id_hi;
        logic [63:0]      id_lo;
        logic [3:0][63:0] key;
        logic [63:0]      nonce;
        logic [63:0]      seq;
    } t_request;

    typedef struct packed {
        logic [1:0]       status;
        logic [3:0][63:0] key;
        logic [63:0]      nonce;
        logic [63:0]      last_seq;
        logic [4:0]       count;
    } t_answer;

    typedef struct packed {
        t_request req;
        logic     typed;
        t_answer  ans;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_action;
    logic [63:0] i_session_id_hi;
    logic [63:0] i_session_id_lo;
    logic [63:0] i_key_word0;
    logic [63:0] i_key_word1;
    logic [63:0] i_key_word2;
    logic [63:0] i_key_word3;
    logic [63:0] i_nonce_prefix;
    logic [63:0] i_sequence_req;
    logic        o_result_valid;
    logic [1:0]  o_status;
    logic [63:0] o_key_out0;
    logic [63:0] o_key_out1;
    logic [63:0] o_key_out2;
    logic [63:0] o_key_out3;
    logic [63:0] o_nonce_out;
    logic [63:0] o_last_seq_out;
    logic [4:0]  o_entry_count;

    session_key_replay_table_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_session_id_hi (i_session_id_hi),
        .i_session_id_lo (i_session_id_lo),
        .i_key_word0     (i_key_word0),
        .i_key_word1     (i_key_word1),
        .i_key_word2     (i_key_word2),
        .i_key_word3     (i_key_word3),
        .i_nonce_prefix  (i_nonce_prefix),
        .i_sequence_req  (i_sequence_req),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_key_out0      (o_key_out0),
        .o_key_out1      (o_key_out1),
        .o_key_out2      (o_key_out2),
        .o_key_out3      (o_key_out3),
        .o_nonce_out     (o_nonce_out),
        .o_last_seq_out  (o_last_seq_out),
        .o_entry_count   (o_entry_count)
    );

    // local copy of the session table
    logic        live     [TABLE_DEPTH];
    logic [63:0] id_hi_mem[TABLE_DEPTH];
    logic [63:0] id_lo_mem[TABLE_DEPTH];
    logic [63:0] key_mem  [TABLE_DEPTH][4];
    logic [63:0] nonce_mem[TABLE_DEPTH];
    logic [63:0] seq_mem  [TABLE_DEPTH];
    int          live_count;

    t_answer     pending_answers[ANSWER_LIMIT];
    int          pending_wr;
    int          pending_rd;
    t_row        directed_rows[ROW_LIMIT];
    int          row_total;
    int          mismatch_count;
    int          no_gap_left;
    logic [63:0] pool_hi[POOL_SIZE];
    logic [63:0] pool_lo[POOL_SIZE];

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic logic [63:0] bits_below(int keep);
        if (keep <= 0) return 64'd0;
        if (keep >= 64) return ALL1;
        return (64'd1 << keep) - 64'd1;
    endfunction

    function automatic int find_slot(logic [63:0] hi, logic [63:0] lo);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (live[i] && id_hi_mem[i] == hi && id_lo_mem[i] == lo) return i;
        end
        return -1;
    endfunction

    function automatic void scrub_entry(int i);
        live[i]      = 1'b0;
        id_hi_mem[i] = '0;
        id_lo_mem[i] = '0;
        for (int w = 0; w < 4; w++) key_mem[i][w] = '0;
        nonce_mem[i] = '0;
        seq_mem[i]   = '0;
    endfunction

    function automatic t_answer table_step(t_request r);
        t_answer a;
        int      slot;
        a    = '0;
        slot = find_slot(r.id_hi, r.id_lo);
        case (r.action)
            ACT_REGISTER: begin
                if (slot < 0) begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (!live[i]) begin
                            slot = i;
                            break;
                        end
                    end
                    if (slot >= 0) live_count++;
                end
                if (slot < 0) begin
                    a.status = STS_FULL;
                end else begin
                    live[slot]      = 1'b1;
                    id_hi_mem[slot] = r.id_hi;
                    id_lo_mem[slot] = r.id_lo;
                    for (int w = 0; w < 4; w++) begin
                        key_mem[slot][w] = r.key[w] & bits_below(KEY_BITS - (3 - w) * 64);
                    end
                    nonce_mem[slot] = r.nonce & bits_below(NONCE_BITS);
                    seq_mem[slot]   = '0;
                end
            end
            ACT_REMOVE: begin
                if (slot < 0) begin
                    a.status = STS_NOT_FOUND;
                end else begin
                    scrub_entry(slot);
                    live_count--;
                end
            end
            ACT_FIND: begin
                if (slot < 0) begin
                    a.status = STS_NOT_FOUND;
                end else begin
                    for (int w = 0; w < 4; w++) a.key[w] = key_mem[slot][w];
                    a.nonce    = nonce_mem[slot];
                    a.last_seq = seq_mem[slot];
                end
            end
            ACT_COMMIT: begin
                if (r.seq == 64'd0) a.status = STS_STALE;
                else if (slot < 0) a.status = STS_NOT_FOUND;
                else if (r.seq <= seq_mem[slot]) a.status = STS_STALE;
                else seq_mem[slot] = r.seq;
            end
            ACT_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) scrub_entry(i);
                live_count = 0;
            end
            default: begin
            end
        endcase
        a.count = 5'(live_count);
        return a;
    endfunction

    function automatic t_request mk_req(logic [2:0] action, logic [63:0] hi, logic [63:0] lo,
                                        logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                                        logic [63:0] k3, logic [63:0] nonce, logic [63:0] seq);
        t_request r;
        r.action = action;
        r.id_hi  = hi;
        r.id_lo  = lo;
        r.key[0] = k0;
        r.key[1] = k1;
        r.key[2] = k2;
        r.key[3] = k3;
        r.nonce  = nonce;
        r.seq    = seq;
        return r;
    endfunction

    function automatic t_answer mk_ans(logic [1:0] status, logic [63:0] k0, logic [63:0] k1,
                                       logic [63:0] k2, logic [63:0] k3, logic [63:0] nonce,
                                       logic [63:0] last_seq, logic [4:0] count);
        t_answer a;
        a.status   = status;
        a.key[0]   = k0;
        a.key[1]   = k1;
        a.key[2]   = k2;
        a.key[3]   = k3;
        a.nonce    = nonce;
        a.last_seq = last_seq;
        a.count    = count;
        return a;
    endfunction

    function automatic void add_row(t_request r, logic typed, t_answer a);
        t_row row;
        row.req   = r;
        row.typed = typed;
        row.ans   = a;
        directed_rows[row_total] = row;
        row_total++;
    endfunction

    function automatic int pick_gap();
        int g;
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        if ($urandom_range(0, 99) == 0) no_gap_left = 30;
        g = $urandom_range(0, 99);
        if (g < 60) return 0;
        if (g < 90) return $urandom_range(1, 3);
        if (g < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return ALL1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic wait_gap(int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // holds start high until the request is taken, then files its answer
    task automatic issue_request(t_request r, logic typed, t_answer typed_ans);
        t_answer a;
        start           <= 1'b1;
        i_action        <= r.action;
        i_session_id_hi <= r.id_hi;
        i_session_id_lo <= r.id_lo;
        i_key_word0     <= r.key[0];
        i_key_word1     <= r.key[1];
        i_key_word2     <= r.key[2];
        i_key_word3     <= r.key[3];
        i_nonce_prefix  <= r.nonce;
        i_sequence_req  <= r.seq;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        a = table_step(r);
        pending_answers[pending_wr] = typed ? typed_ans : a;
        pending_wr++;
    endtask

    task automatic check_field(string name, logic [63:0] exp, logic [63:0] act);
        if (exp !== act) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t %s: expected %h, got %h", $realtime, name, exp, act);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1) begin
            if (pending_rd == pending_wr) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t result with no request pending, status %h",
                             $realtime, o_status);
                end
            end else begin
                e = pending_answers[pending_rd];
                pending_rd++;
                check_field("status", 64'(e.status), 64'(o_status));
                check_field("key_out0", e.key[0], o_key_out0);
                check_field("key_out1", e.key[1], o_key_out1);
                check_field("key_out2", e.key[2], o_key_out2);
                check_field("key_out3", e.key[3], o_key_out3);
                check_field("nonce_out", e.nonce, o_nonce_out);
                check_field("last_seq_out", e.last_seq, o_last_seq_out);
                check_field("entry_count", 64'(e.count), 64'(o_entry_count));
            end
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("session_key_replay_table_core: mismatch");
        $finish;
    end

    initial begin
        t_request    r;
        t_row        row;
        logic [63:0] a_hi;
        logic [63:0] a_lo;
        logic [63:0] base;
        int          pick;
        int          idx;
        int          slot;

        mismatch_count   = 0;
        no_gap_left      = 0;
        live_count       = 0;
        pending_wr       = 0;
        pending_rd       = 0;
        row_total        = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) scrub_entry(i);

        start           <= 1'b0;
        i_rst_n         <= 1'b0;
        i_action        <= '0;
        i_session_id_hi <= '0;
        i_session_id_lo <= '0;
        i_key_word0     <= '0;
        i_key_word1     <= '0;
        i_key_word2     <= '0;
        i_key_word3     <= '0;
        i_nonce_prefix  <= '0;
        i_sequence_req  <= '0;

        a_hi = 64'h0123_4567_89ab_cdef;
        a_lo = 64'hfedc_ba98_7654_3210;

        add_row(mk_req(ACT_FIND, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 5'd0));
        add_row(mk_req(ACT_COMMIT, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_STALE, 0, 0, 0, 0, 0, 0, 5'd0));
        add_row(mk_req(ACT_COMMIT, a_hi, a_lo, 0, 0, 0, 0, 0, 64'd5), 1'b1,
                mk_ans(STS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 5'd0));
        add_row(mk_req(ACT_REMOVE, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 5'd0));
        add_row(mk_req(ACT_REGISTER, a_hi, a_lo, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd1));
        add_row(mk_req(ACT_FIND, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_OK, ALL1, ALL1, ALL1, ALL1, ALL1, 0, 5'd1));
        add_row(mk_req(ACT_COMMIT, a_hi, a_lo, 0, 0, 0, 0, 0, ALL1), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd1));
        add_row(mk_req(ACT_COMMIT, a_hi, a_lo, 0, 0, 0, 0, 0, ALL1), 1'b1,
                mk_ans(STS_STALE, 0, 0, 0, 0, 0, 0, 5'd1));
        add_row(mk_req(ACT_FIND, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_OK, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, 5'd1));
        add_row(mk_req(ACT_REGISTER, a_hi, a_lo, 64'ha5a5_5a5a_0f0f_f0f0, 64'h8000_0000_0000_0001,
                       64'h0000_0000_0000_0000, 64'h1234_5678_9abc_def0, 64'd0, 64'd9), 1'b0, '0);
        add_row(mk_req(ACT_FIND, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(ACT_COMMIT, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_STALE, 0, 0, 0, 0, 0, 0, 5'd1));
        add_row(mk_req(ACT_COMMIT, a_hi, a_lo, 0, 0, 0, 0, 0, 64'd1), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd1));
        add_row(mk_req(ACT_REGISTER, 0, 0, 64'h0000_ffff_0000_ffff, ALL1, 64'd0,
                       64'hdead_beef_cafe_f00d, 64'h5555_aaaa_5555_aaaa, 0), 1'b0, '0);
        add_row(mk_req(ACT_FIND, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
        add_row(mk_req(ACT_FIND, 0, 64'd1, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 5'd2));
        add_row(mk_req(ACT_SPARE_LO, a_hi, a_lo, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd2));
        add_row(mk_req(ACT_SPARE_HI, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd2));
        add_row(mk_req(ACT_REMOVE, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd1));
        add_row(mk_req(ACT_FIND, a_hi, a_lo, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 5'd1));
        add_row(mk_req(ACT_COMMIT, 0, 0, 0, 0, 0, 0, 0, 64'd1), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd1));
        add_row(mk_req(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd0));
        add_row(mk_req(ACT_FIND, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                mk_ans(STS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 5'd0));
        add_row(mk_req(ACT_REGISTER, a_hi, a_lo, ALL1, ALL1, ALL1, ALL1, ALL1, 0), 1'b1,
                mk_ans(STS_OK, 0, 0, 0, 0, 0, 0, 5'd1));

        // id pool: extremes, ids sharing one half, the rest random
        pool_hi[0] = ALL1;  pool_lo[0] = ALL1;
        pool_hi[1] = ALL1;  pool_lo[1] = 64'd0;
        pool_hi[2] = 64'd0; pool_lo[2] = 64'd0;
        pool_hi[3] = 64'd0; pool_lo[3] = ALL1;
        pool_hi[4] = a_hi;  pool_lo[4] = a_lo;
        for (int i = 5; i < POOL_SIZE; i++) begin
            pool_hi[i] = (i % 4 == 0) ? pool_hi[i - 1] : {$urandom, $urandom};
            pool_lo[i] = (i % 4 == 1) ? pool_lo[i - 1] : {$urandom, $urandom};
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < row_total; n++) begin
            row = directed_rows[n];
            wait_gap(pick_gap());
            issue_request(row.req, row.typed, row.ans);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 9) < 8) begin
                idx     = $urandom_range(0, POOL_SIZE - 1);
                r.id_hi = pool_hi[idx];
                r.id_lo = pool_lo[idx];
            end else begin
                r.id_hi = {$urandom, $urandom};
                r.id_lo = {$urandom, $urandom};
            end
            for (int w = 0; w < 4; w++) r.key[w] = rand_word();
            r.nonce = rand_word();
            r.seq   = rand_word();
            if (pick < 32) r.action = ACT_REGISTER;
            else if (pick < 40) r.action = ACT_REMOVE;
            else if (pick < 64) r.action = ACT_FIND;
            else if (pick < 95) r.action = ACT_COMMIT;
            else if (pick < 96) r.action = ACT_CLEAR;
            else r.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            if (r.action == ACT_COMMIT) begin
                slot = find_slot(r.id_hi, r.id_lo);
                base = (slot >= 0) ? seq_mem[slot] : 64'd0;
                case ($urandom_range(0, 9))
                    0:       r.seq = 64'd0;
                    1:       r.seq = base;
                    2:       r.seq = base - 64'($urandom_range(1, 3));
                    3:       r.seq = {$urandom, $urandom};
                    4:       r.seq = ALL1;
                    default: r.seq = base + 64'($urandom_range(1, 5));
                endcase
            end
            wait_gap(pick_gap());
            issue_request(r, 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_rd != pending_wr) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("session_key_replay_table_core: match");
        end else begin
            $display("session_key_replay_table_core: mismatch");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/skrt_pkg.sv
hw/rtl/skrt_ram.sv
hw/rtl/skrt_ctrl.sv
hw/rtl/skrt_datapath.sv
hw/rtl/session_key_replay_table_core.sv
tb/tb_session_key_replay_table_core.sv
